// ===== hdl/cdf_pkg.sv =====
package cdf_pkg;

	localparam int MAX_FACILITIES = 1024;
	localparam int COST_BITS      = 20;

	localparam int COST_W  = 20;
	localparam int SUM_W   = 21;
	localparam int INDEX_W = 11;
	localparam int DEG_W   = 11;
	localparam int ELIM_W  = 24;

	localparam logic [SUM_W-1:0] START_SUM = SUM_W'(1000000);

	localparam int COST_USE = (COST_BITS < COST_W) ? COST_BITS : COST_W;
	localparam logic [COST_W-1:0] COST_MASK = COST_W'((64'd1 << COST_USE) - 64'd1);

	localparam int DEG_CAP_INT = (MAX_FACILITIES < 2047) ? MAX_FACILITIES : 2047;
	localparam logic [DEG_W-1:0] DEG_CAP  = DEG_W'(DEG_CAP_INT);
	localparam logic [ELIM_W-1:0] ELIM_CAP = {ELIM_W{1'b1}};

	localparam logic MODE_MIN    = 1'b0;
	localparam logic MODE_FILTER = 1'b1;

	typedef struct packed {
		logic               mode;
		logic               first;
		logic               last;
		logic               restart;
		logic [INDEX_W-1:0] facility_index;
		logic [COST_W-1:0]  opening_cost;
		logic [COST_W-1:0]  link_cost;
	} item_t;

	typedef struct packed {
		logic               retained;
		logic [DEG_W-1:0]   slot;
		logic [INDEX_W-1:0] facility_echo;
		logic [SUM_W-1:0]   best_sum;
		logic [DEG_W-1:0]   client_degree;
		logic [ELIM_W-1:0]  eliminated_total;
		logic [DEG_W-1:0]   top_degree;
		logic               client_done;
	} result_t;

endpackage

// ===== hdl/cdf_step.sv =====
module cdf_step
	import cdf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    enable,
	input  item_t   item,
	output result_t result
);

	logic [SUM_W-1:0]  best_q;
	logic [DEG_W-1:0]  deg_q;
	logic [ELIM_W-1:0] elim_q;
	logic [DEG_W-1:0]  larg_q;

	logic [SUM_W-1:0]  best_n;
	logic [DEG_W-1:0]  deg_n;
	logic [ELIM_W-1:0] elim_n;
	logic [DEG_W-1:0]  larg_n;

	logic [COST_W-1:0] open_c;
	logic [COST_W-1:0] link_c;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  best_base;
	logic [DEG_W-1:0]  deg_base;
	logic [ELIM_W-1:0] elim_base;
	logic [DEG_W-1:0]  larg_base;
	logic              keep;

	always_comb begin
		open_c    = item.opening_cost & COST_MASK;
		link_c    = item.link_cost & COST_MASK;
		sum       = {1'b0, open_c} + {1'b0, link_c};
		elim_base = item.restart ? '0 : elim_q;
		larg_base = item.restart ? '0 : larg_q;
		best_base = item.first ? START_SUM : best_q;
		deg_base  = item.first ? '0 : deg_q;
		keep      = 1'b0;
		best_n    = best_q;
		deg_n     = deg_q;
		elim_n    = elim_base;
		larg_n    = larg_base;

		result = '0;
		result.facility_echo = item.facility_index;

		if (item.mode == MODE_MIN) begin
			best_n = (sum < best_base) ? sum : best_base;
		end else begin
			keep = ({1'b0, link_c} <= best_q);
			if (keep) begin
				deg_n = (deg_base < DEG_CAP) ? deg_base + DEG_W'(1) : deg_base;
			end else begin
				deg_n = deg_base;
				if (elim_base < ELIM_CAP)
					elim_n = elim_base + ELIM_W'(1);
			end
			// completed client degree folds into the running maximum
			if (item.last && (deg_n > larg_base))
				larg_n = deg_n;
			result.retained    = keep;
			result.slot        = keep ? deg_n : '0;
			result.client_done = item.last;
		end

		result.best_sum         = best_n;
		result.client_degree    = deg_n;
		result.eliminated_total = elim_n;
		result.top_degree       = larg_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= START_SUM;
			deg_q  <= '0;
			elim_q <= '0;
			larg_q <= '0;
		end else if (enable) begin
			best_q <= best_n;
			deg_q  <= deg_n;
			elim_q <= elim_n;
			larg_q <= larg_n;
		end
	end

endmodule

// ===== hdl/client_dominance_filter.sv =====
// client dominance filter, one client at a time over two passes of the
// facility stream: a minimum pass (mode 0) keeps the least opening plus
// link cost, a filter pass (mode 1) retains facilities whose link cost is
// at most that minimum and numbers them in the retained list.
// item channel: item_valid / item_stall with the input fields as ports;
// a beat is taken at a rising edge with item_valid high and item_stall low.
// result channel: result_valid / result_stall, one result beat per item.
// an input register, then the cost add, compare and counter updates into the
// result register. throughput is one item per cycle while the receiver
// does not stall, set by the single add-compare path against the state
// registers. while the receiver stalls the held result stays put and one
// further item waits in the input register; item_stall rises only when
// both are full. reset clears both valid flags, sets the kept minimum to
// 1000000 and clears the degree, eliminated total and maximum degree.
module client_dominance_filter
	import cdf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               mode,
	input  logic               first,
	input  logic               last,
	input  logic               restart,
	input  logic [INDEX_W-1:0] facility_index,
	input  logic [COST_W-1:0]  opening_cost,
	input  logic [COST_W-1:0]  link_cost,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               retained,
	output logic [DEG_W-1:0]   slot,
	output logic [INDEX_W-1:0] facility_echo,
	output logic [SUM_W-1:0]   best_sum,
	output logic [DEG_W-1:0]   client_degree,
	output logic [ELIM_W-1:0]  eliminated_total,
	output logic [DEG_W-1:0]   top_degree,
	output logic               client_done
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_n;
	logic    advance;
	logic    step_en;

	assign advance    = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign step_en    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= '{mode: mode, first: first, last: last, restart: restart,
				facility_index: facility_index, opening_cost: opening_cost,
				link_cost: link_cost};
		end
	end

	cdf_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.enable (step_en),
		.item   (item_s1),
		.result (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en)
			result_s2 <= result_n;
	end

	assign result_valid     = valid_s2;
	assign retained         = result_s2.retained;
	assign slot             = result_s2.slot;
	assign facility_echo    = result_s2.facility_echo;
	assign best_sum         = result_s2.best_sum;
	assign client_degree    = result_s2.client_degree;
	assign eliminated_total = result_s2.eliminated_total;
	assign top_degree       = result_s2.top_degree;
	assign client_done      = result_s2.client_done;

	a_slot_retained: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (slot != '0) |-> retained)
		else $error("slot given to an item that was not retained");

	a_slot_degree: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && retained |-> (slot == client_degree))
		else $error("retained slot differs from client degree");

	a_top_degree: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && client_done |-> (top_degree >= client_degree))
		else $error("maximum degree below finished client degree");

	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (best_sum <= START_SUM))
		else $error("kept minimum above start value");

endmodule

// ===== dv/client_dominance_filter_test.sv =====
`timescale 1ns / 100ps

module client_dominance_filter_test;
	import cdf_pkg::*;

	class dominance_board;
		logic [SUM_W-1:0]  least_sum;
		logic [DEG_W-1:0]  degree;
		logic [ELIM_W-1:0] dropped;
		logic [DEG_W-1:0]  peak_degree;
		result_t           outcomes_due[$];
		int                errors;
		int                checked;

		function new();
			least_sum   = START_SUM;
			degree      = '0;
			dropped     = '0;
			peak_degree = '0;
			errors      = 0;
			checked     = 0;
		endfunction

		function int outstanding();
			return outcomes_due.size();
		endfunction

		// work out what the filter should give for an accepted item beat
		function void note_item(item_t it);
			result_t            r;
			logic [COST_W-1:0]  oc;
			logic [COST_W-1:0]  lc;
			logic [SUM_W:0]     total;
			r  = '0;
			oc = it.opening_cost & COST_MASK;
			lc = it.link_cost & COST_MASK;
			if (it.restart) begin
				dropped     = '0;
				peak_degree = '0;
			end
			if (it.mode == MODE_MIN) begin
				total = (SUM_W+1)'(oc) + (SUM_W+1)'(lc);
				if (it.first)
					least_sum = START_SUM;
				if (total < (SUM_W+1)'(least_sum))
					least_sum = total[SUM_W-1:0];
			end else begin
				if (it.first)
					degree = '0;
				if ((SUM_W+1)'(lc) <= (SUM_W+1)'(least_sum)) begin
					r.retained = 1'b1;
					if (degree < DEG_CAP)
						degree = degree + DEG_W'(1);
					r.slot = degree;
				end else if (dropped < ELIM_CAP) begin
					dropped = dropped + ELIM_W'(1);
				end
				if (it.last) begin
					r.client_done = 1'b1;
					if (degree > peak_degree)
						peak_degree = degree;
				end
			end
			r.facility_echo    = it.facility_index;
			r.best_sum         = least_sum;
			r.client_degree    = degree;
			r.eliminated_total = dropped;
			r.top_degree       = peak_degree;
			outcomes_due.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (outcomes_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result beat with nothing due (facility %0d)",
						$time, got.facility_echo);
				return;
			end
			want = outcomes_due.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: mismatch on result %0d", $time, checked);
					$display("  exp keep %0b slot %0d fac %0d best %0d deg %0d elim %0d max %0d done %0b",
						want.retained, want.slot, want.facility_echo, want.best_sum,
						want.client_degree, want.eliminated_total, want.top_degree,
						want.client_done);
					$display("  got keep %0b slot %0d fac %0d best %0d deg %0d elim %0d max %0d done %0b",
						got.retained, got.slot, got.facility_echo, got.best_sum,
						got.client_degree, got.eliminated_total, got.top_degree,
						got.client_done);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic               mode;
	logic               first;
	logic               last;
	logic               restart;
	logic [INDEX_W-1:0] facility_index;
	logic [COST_W-1:0]  opening_cost;
	logic [COST_W-1:0]  link_cost;
	logic               result_valid;
	logic               result_stall;
	logic               retained;
	logic [DEG_W-1:0]   slot;
	logic [INDEX_W-1:0] facility_echo;
	logic [SUM_W-1:0]   best_sum;
	logic [DEG_W-1:0]   client_degree;
	logic [ELIM_W-1:0]  eliminated_total;
	logic [DEG_W-1:0]   top_degree;
	logic               client_done;

	dominance_board board = new();
	int             sent;
	int             received;
	int             clients;

	client_dominance_filter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.mode             (mode),
		.first            (first),
		.last             (last),
		.restart          (restart),
		.facility_index   (facility_index),
		.opening_cost     (opening_cost),
		.link_cost        (link_cost),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.retained         (retained),
		.slot             (slot),
		.facility_echo    (facility_echo),
		.best_sum         (best_sum),
		.client_degree    (client_degree),
		.eliminated_total (eliminated_total),
		.top_degree       (top_degree),
		.client_done      (client_done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic item_t make_item(logic m, logic f, logic l, logic rs,
			logic [INDEX_W-1:0] fac, logic [COST_W-1:0] oc, logic [COST_W-1:0] lc);
		item_t it;
		it.mode           = m;
		it.first          = f;
		it.last           = l;
		it.restart        = rs;
		it.facility_index = fac;
		it.opening_cost   = oc;
		it.link_cost      = lc;
		return it;
	endfunction

	function automatic logic [COST_W-1:0] pick_cost(int scale);
		case (scale)
			0: return COST_W'($urandom);
			1: return COST_W'($urandom_range(0, 600000));
			default: return COST_W'($urandom_range(0, 2000));
		endcase
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return INDEX_W'($urandom);
		return INDEX_W'($urandom_range(1, MAX_FACILITIES));
	endfunction

	task automatic offer(item_t it);
		// no gaps on the sender side over one stretch of the run
		while (!(sent >= 300 && sent < 500) && $urandom_range(0, 99) < 26) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid     <= 1'b1;
		mode           <= it.mode;
		first          <= it.first;
		last           <= it.last;
		restart        <= it.restart;
		facility_index <= it.facility_index;
		opening_cost   <= it.opening_cost;
		link_cost      <= it.link_cost;
		do
			@(posedge clk);
		while (item_stall);
		board.note_item(it);
		sent++;
	endtask

	// one client: a minimum pass then a filter pass over the same facilities
	// link_style 0 reuses the minimum pass link costs, 1 draws fresh, 2 zero
	task automatic run_client(int min_span, int filt_span, bit sloppy, int link_style);
		logic [COST_W-1:0]  links[$];
		logic [INDEX_W-1:0] facs[$];
		item_t              it;
		int                 scale;
		scale = $urandom_range(0, 2);
		for (int k = 0; k < min_span; k++) begin
			it = make_item(MODE_MIN, k == 0, k == min_span - 1,
				$urandom_range(0, 99) < 3, pick_index(), pick_cost(scale), pick_cost(scale));
			if (sloppy) begin
				it.first = 1'($urandom);
				it.last  = 1'($urandom);
			end
			facs.push_back(it.facility_index);
			links.push_back(it.link_cost);
			offer(it);
		end
		for (int k = 0; k < filt_span; k++) begin
			it = make_item(MODE_FILTER, k == 0, k == filt_span - 1,
				$urandom_range(0, 99) < 3, facs[k % min_span], pick_cost(0),
				(link_style == 0) ? links[k % min_span] :
				(link_style == 1) ? pick_cost(scale) : '0);
			if (sloppy) begin
				it.first = 1'($urandom);
				it.last  = 1'($urandom);
			end
			offer(it);
		end
		clients++;
	endtask

	initial begin : result_side
		int      hold;
		result_t seen;
		hold = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				seen.retained         = retained;
				seen.slot             = slot;
				seen.facility_echo    = facility_echo;
				seen.best_sum         = best_sum;
				seen.client_degree    = client_degree;
				seen.eliminated_total = eliminated_total;
				seen.top_degree       = top_degree;
				seen.client_done      = client_done;
				board.check_result(seen);
				received++;
				// long hold-off so the block backs up into the item side
				if (received == 250)
					hold = 120;
			end
			if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else if (received >= 300 && received < 500) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(0, 99) < 26);
			end
		end
	end

	initial begin : item_side
		int target;
		int drain;
		bit long_done;
		sent           = 0;
		received       = 0;
		clients        = 0;
		long_done      = 1'b0;
		arst_n         <= 1'b0;
		item_valid     <= 1'b0;
		mode           <= MODE_MIN;
		first          <= 1'b0;
		last           <= 1'b0;
		restart        <= 1'b0;
		facility_index <= '0;
		opening_cost   <= '0;
		link_cost      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero and all-ones costs and indexes
		offer(make_item(MODE_MIN, 1, 0, 1, '0, '0, '0));
		offer(make_item(MODE_MIN, 0, 1, 0, '1, '1, '1));
		offer(make_item(MODE_FILTER, 1, 0, 0, 11'd1, '1, '0));
		offer(make_item(MODE_FILTER, 0, 0, 0, 11'd1024, '0, '1));
		offer(make_item(MODE_FILTER, 0, 1, 0, 11'd2, '0, 20'd1));
		// sum equal to the start value does not lower the minimum
		offer(make_item(MODE_MIN, 1, 0, 0, 11'd3, 20'd999999, 20'd1));
		offer(make_item(MODE_MIN, 0, 1, 0, 11'd4, 20'd500000, 20'd499999));
		// link equal to the minimum is retained, one above is eliminated
		offer(make_item(MODE_FILTER, 1, 0, 0, 11'd3, '0, 20'd999999));
		offer(make_item(MODE_FILTER, 0, 0, 0, 11'd4, '0, 20'd1000000));
		offer(make_item(MODE_FILTER, 0, 1, 0, 11'd5, '0, 20'd0));
		// minimum pass with no first mark carries on the old minimum
		offer(make_item(MODE_MIN, 0, 0, 0, 11'd6, 20'd0, 20'd5));
		offer(make_item(MODE_MIN, 0, 1, 0, 11'd7, 20'd3, 20'd3));
		// filter pass with no first mark carries the degree
		offer(make_item(MODE_FILTER, 0, 0, 0, 11'd6, '0, 20'd5));
		offer(make_item(MODE_FILTER, 0, 1, 0, 11'd7, '0, 20'd6));
		// single item client, first and last together, with restart
		offer(make_item(MODE_MIN, 1, 1, 1, 11'd8, 20'd10, 20'd20));
		offer(make_item(MODE_FILTER, 1, 1, 0, 11'd8, '0, 20'd20));
		// restart in the middle of a filter pass
		offer(make_item(MODE_FILTER, 1, 0, 0, 11'd9, '0, 20'd30));
		offer(make_item(MODE_FILTER, 0, 1, 1, 11'd10, '0, 20'd0));
		offer(make_item(MODE_MIN, 1, 0, 0, 11'd11, '1, 20'd0));
		offer(make_item(MODE_MIN, 0, 1, 0, 11'd12, 20'd0, '1));

		// let everything out before the random part
		item_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);

		target = sent + 1000;
		while (sent < target) begin
			if (!long_done && sent > 120) begin
				// enough retained edges to run the degree into its cap
				run_client(1, MAX_FACILITIES + 6, 0, 2);
				long_done = 1'b1;
			end else if ($urandom_range(0, 99) < 8) begin
				repeat ($urandom_range(1, 6))
					offer(make_item(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
						INDEX_W'($urandom), COST_W'($urandom), COST_W'($urandom)));
			end else begin
				run_client($urandom_range(1, 8), $urandom_range(1, 8),
					$urandom_range(0, 9) == 0, $urandom_range(0, 1));
			end
		end
		item_valid <= 1'b0;

		drain = 0;
		while (board.outstanding() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (board.outstanding() != 0) begin
			board.errors += board.outstanding();
			$display("%0d expected results never arrived", board.outstanding());
		end

		$display("ran %0d item beats over %0d clients plus noise, %0d result beats checked",
			sent, clients, board.checked);
		$display("degree cap, sloppy marks, restarts and backpressure exercised, %0d mismatches",
			board.errors);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d results still due", board.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
